// ===== rtl/core/olt_pkg.sv =====
// shared definitions for the ordered list table: command and status codes,
// controller states and the command/status structs between controller and datapath
// no dependencies
package olt_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int VAL_W     = 32;
  localparam int CMD_W     = 3;
  localparam int POS_W     = 6;
  localparam int STS_W     = 3;
  localparam int FND_W     = 6;
  localparam int CNT_W     = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_POP_BACK   = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_ERASE      = 3'd5,
    CMD_FIND       = 3'd6
  } cmd_t;

  localparam logic [STS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STS_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STS_W-1:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_UP,
    S_DN,
    S_FIND,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic             init_up;
    logic             init_dn;
    logic             init_find;
    logic             step_up;
    logic             step_dn;
    logic             step_find;
    logic             put_value;
    logic             put_back;
    logic             dec_count;
    logic             set_status;
    logic [STS_W-1:0] status;
    logic             set_found;
    logic             load_out;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             ins_bad;
    logic             era_bad;
    logic             shift_live;
    logic             find_live;
    logic             hit;
    logic             out_busy;
  } stat_t;

endpackage

// ===== rtl/core/olt_ram.sv =====
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies
module olt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/olt_datapath.sv =====
// datapath of the ordered list table: item registers, entry store, walk pointers,
// entry count and output register
// depends on olt_pkg and olt_ram
module olt_datapath #(
  parameter int DEPTH = olt_pkg::DEPTH_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  olt_pkg::ctrl_t            ctrl,
  output olt_pkg::stat_t            stat,
  input  logic [olt_pkg::CMD_W-1:0] in_command,
  input  logic [olt_pkg::POS_W-1:0] in_position,
  input  logic [olt_pkg::VAL_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [olt_pkg::STS_W-1:0] out_status,
  output logic [olt_pkg::FND_W-1:0] out_found,
  output logic [olt_pkg::CNT_W-1:0] out_count
);

  localparam int PW = (CW > olt_pkg::POS_W) ? CW : olt_pkg::POS_W;
  localparam int FW = (AW > olt_pkg::FND_W) ? AW : olt_pkg::FND_W;
  localparam int OW = (CW > olt_pkg::CNT_W) ? CW : olt_pkg::CNT_W;

  logic [olt_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [PW-1:0]             pos_r, pos_nxt;
  logic [olt_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [AW-1:0]             rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]             left_r, left_nxt;
  logic [AW-1:0]             wa_r, wa_nxt;
  logic                      pend_r, pend_nxt;
  logic                      fpend_r, fpend_nxt;
  logic [olt_pkg::STS_W-1:0] res_status_r, res_status_nxt;
  logic [AW-1:0]             res_found_r, res_found_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [olt_pkg::STS_W-1:0] out_status_r, out_status_nxt;
  logic [olt_pkg::FND_W-1:0] out_found_r, out_found_nxt;
  logic [olt_pkg::CNT_W-1:0] out_count_r, out_count_nxt;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [olt_pkg::VAL_W-1:0] ram_wdata;
  logic                      ram_re;
  logic [olt_pkg::VAL_W-1:0] ram_rdata;

  logic                      front;
  logic [CW-1:0]             pos_cw;
  logic [AW-1:0]             pos_a;
  logic [PW-1:0]             count_pw;
  logic                      issue;
  logic [FW-1:0]             found_ext;
  logic [OW-1:0]             count_ext;

  olt_ram #(
    .WIDTH(olt_pkg::VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(rd_ptr_r),
    .rdata(ram_rdata)
  );

  assign front = (in_command == olt_pkg::CMD_PUSH_FRONT) ||
                 (in_command == olt_pkg::CMD_POP_FRONT);
  // positions that reach the store are already checked against the count
  assign pos_cw    = pos_r[CW-1:0];
  assign pos_a     = pos_r[AW-1:0];
  assign count_pw  = PW'(count_r);
  assign issue     = (ctrl.step_up || ctrl.step_dn || ctrl.step_find) && (left_r != '0);
  assign found_ext = FW'(res_found_r);
  assign count_ext = OW'(count_r);

  assign stat.cmd        = cmd_r;
  assign stat.full       = (count_r == CW'(DEPTH));
  assign stat.empty      = (count_r == '0);
  assign stat.ins_bad    = (pos_r > count_pw);
  assign stat.era_bad    = (pos_r >= count_pw);
  assign stat.shift_live = (left_r != '0) || pend_r;
  assign stat.find_live  = (left_r != '0) || fpend_r;
  assign stat.hit        = fpend_r && (ram_rdata == val_r);
  assign stat.out_busy   = out_valid_r && !out_ready;

  always_comb begin
    cmd_nxt        = cmd_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    count_nxt      = count_r;
    rd_ptr_nxt     = rd_ptr_r;
    left_nxt       = left_r;
    wa_nxt         = wa_r;
    pend_nxt       = issue && (ctrl.step_up || ctrl.step_dn);
    fpend_nxt      = issue && ctrl.step_find;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    ram_re         = issue;
    ram_we         = 1'b0;
    ram_waddr      = wa_r;
    ram_wdata      = ram_rdata;

    if (ctrl.load) begin
      cmd_nxt        = in_command;
      pos_nxt        = front ? '0 : PW'(in_position);
      val_nxt        = in_value;
      res_status_nxt = olt_pkg::ST_OK;
      res_found_nxt  = '0;
    end

    if (ctrl.init_up) begin
      rd_ptr_nxt = AW'(count_r - CW'(1));
      left_nxt   = count_r - pos_cw;
    end
    if (ctrl.init_dn) begin
      rd_ptr_nxt = pos_a + AW'(1);
      left_nxt   = count_r - pos_cw - CW'(1);
    end
    if (ctrl.init_find) begin
      rd_ptr_nxt = '0;
      left_nxt   = count_r;
    end

    if (issue) begin
      left_nxt = left_r - CW'(1);
      if (ctrl.step_up) begin
        rd_ptr_nxt = rd_ptr_r - AW'(1);
        wa_nxt     = rd_ptr_r + AW'(1);
      end else if (ctrl.step_dn) begin
        rd_ptr_nxt = rd_ptr_r + AW'(1);
        wa_nxt     = rd_ptr_r - AW'(1);
      end else begin
        rd_ptr_nxt = rd_ptr_r + AW'(1);
        wa_nxt     = rd_ptr_r;
      end
    end

    // a moved entry is written in the cycle after its read
    if (pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = wa_r;
      ram_wdata = ram_rdata;
    end else if (ctrl.put_value) begin
      ram_we    = 1'b1;
      ram_waddr = pos_a;
      ram_wdata = val_r;
    end else if (ctrl.put_back) begin
      ram_we    = 1'b1;
      ram_waddr = count_r[AW-1:0];
      ram_wdata = val_r;
    end

    if (ctrl.put_value || ctrl.put_back) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.dec_count) begin
      count_nxt = count_r - CW'(1);
    end

    if (ctrl.set_status) begin
      res_status_nxt = ctrl.status;
    end
    if (ctrl.set_found) begin
      res_found_nxt = wa_r;
    end

    if (ctrl.load_out) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_found_nxt  = found_ext[olt_pkg::FND_W-1:0];
      out_count_nxt  = count_ext[olt_pkg::CNT_W-1:0];
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      left_r      <= '0;
      pend_r      <= 1'b0;
      fpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      pend_r      <= pend_nxt;
      fpend_r     <= fpend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    wa_r         <= wa_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_found  = out_found_r;
  assign out_count  = out_count_r;

endmodule

// ===== rtl/core/olt_ctrl.sv =====
// controller of the ordered list table: decodes each item and sequences the
// shift and search walks over the entry store
// depends on olt_pkg
module olt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  olt_pkg::stat_t stat,
  output olt_pkg::ctrl_t ctrl
);

  olt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= olt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    ctrl.status = olt_pkg::ST_OK;
    in_ready  = 1'b0;

    case (state_r)
      olt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          state_nxt = olt_pkg::S_DECODE;
        end
      end

      olt_pkg::S_DECODE: begin
        state_nxt = olt_pkg::S_FINISH;
        case (stat.cmd)
          olt_pkg::CMD_PUSH_BACK: begin
            if (stat.full) begin
              ctrl.set_status = 1'b1;
              ctrl.status     = olt_pkg::ST_FULL;
            end else begin
              ctrl.put_back = 1'b1;
            end
          end
          olt_pkg::CMD_POP_BACK: begin
            if (stat.empty) begin
              ctrl.set_status = 1'b1;
              ctrl.status     = olt_pkg::ST_EMPTY;
            end else begin
              ctrl.dec_count = 1'b1;
            end
          end
          olt_pkg::CMD_PUSH_FRONT, olt_pkg::CMD_INSERT: begin
            // full is checked before the position
            if (stat.full) begin
              ctrl.set_status = 1'b1;
              ctrl.status     = olt_pkg::ST_FULL;
            end else if (stat.ins_bad) begin
              ctrl.set_status = 1'b1;
              ctrl.status     = olt_pkg::ST_BADPOS;
            end else begin
              ctrl.init_up = 1'b1;
              state_nxt    = olt_pkg::S_UP;
            end
          end
          olt_pkg::CMD_POP_FRONT, olt_pkg::CMD_ERASE: begin
            if (stat.empty) begin
              ctrl.set_status = 1'b1;
              ctrl.status     = olt_pkg::ST_EMPTY;
            end else if (stat.era_bad) begin
              ctrl.set_status = 1'b1;
              ctrl.status     = olt_pkg::ST_BADPOS;
            end else begin
              ctrl.init_dn = 1'b1;
              state_nxt    = olt_pkg::S_DN;
            end
          end
          olt_pkg::CMD_FIND: begin
            ctrl.init_find = 1'b1;
            state_nxt      = olt_pkg::S_FIND;
          end
          default: begin
            state_nxt = olt_pkg::S_FINISH;
          end
        endcase
      end

      olt_pkg::S_UP: begin
        if (stat.shift_live) begin
          ctrl.step_up = 1'b1;
        end else begin
          // gap is open, drop the new value in
          ctrl.put_value = 1'b1;
          state_nxt      = olt_pkg::S_FINISH;
        end
      end

      olt_pkg::S_DN: begin
        if (stat.shift_live) begin
          ctrl.step_dn = 1'b1;
        end else begin
          ctrl.dec_count = 1'b1;
          state_nxt      = olt_pkg::S_FINISH;
        end
      end

      olt_pkg::S_FIND: begin
        if (stat.hit) begin
          ctrl.set_found = 1'b1;
          state_nxt      = olt_pkg::S_FINISH;
        end else if (!stat.find_live) begin
          ctrl.set_status = 1'b1;
          ctrl.status     = olt_pkg::ST_NOTFOUND;
          state_nxt       = olt_pkg::S_FINISH;
        end else begin
          ctrl.step_find = 1'b1;
        end
      end

      olt_pkg::S_FINISH: begin
        if (!stat.out_busy) begin
          ctrl.load_out = 1'b1;
          state_nxt     = olt_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = olt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ordered_list_table.sv =====
// ordered list table: packed list of 32-bit values with push, pop, insert, erase, find
// each item is accepted in idle and checked in decode; insert, erase, front items and find
// then walk the entry store, and every item ends in finish, which loads the result
// register once it is free; a new item is taken only after the flow is back in idle
// the walk moves or compares one entry per cycle
// reset clears the entry count and handshake state; store contents are not cleared
module ordered_list_table #(
  parameter int DEPTH = olt_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position [5:0], value [37:6], zero pad [39:38]
  input  logic [2:0]  in_tuser,   // command [2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // found_index [5:0], count [12:6], zero pad [15:13]
  output logic [2:0]  out_tuser   // status [2:0]
);

  olt_pkg::ctrl_t ctrl;
  olt_pkg::stat_t stat;

  logic [olt_pkg::STS_W-1:0] status;
  logic [olt_pkg::FND_W-1:0] found_index;
  logic [olt_pkg::CNT_W-1:0] count;

  olt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .stat    (stat),
    .ctrl    (ctrl)
  );

  olt_datapath #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_command (in_tuser),
    .in_position(in_tdata[5:0]),
    .in_value   (in_tdata[37:6]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (status),
    .out_found  (found_index),
    .out_count  (count)
  );

  assign out_tdata = {3'b000, count, found_index};
  assign out_tuser = status;

endmodule

// ===== rtl/core/olt_checker.sv =====
// port-level checks for the ordered list table, attached by bind
// depends on olt_pkg and ordered_list_table
module olt_checker #(
  parameter int DEPTH = olt_pkg::DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // only a successful find reports an index: a result whose status is not ok carries index zero
  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != olt_pkg::ST_OK) |-> out_tdata[5:0] == 6'd0)
    else $error("nonzero index on a result that is not a hit");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == olt_pkg::ST_FULL) |-> out_tdata[12:6] == 7'(DEPTH))
    else $error("full reported below capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == olt_pkg::ST_EMPTY) |-> out_tdata[12:6] == 7'd0)
    else $error("empty reported with entries present");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (DEPTH > 127) || (int'(out_tdata[12:6]) <= DEPTH))
    else $error("count above capacity");

endmodule

bind ordered_list_table olt_checker #(
  .DEPTH(DEPTH)
) u_olt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for ordered_list_table: queue-fed stream driver, result monitor
// and a cycle-free predictor of the list contents, count, found index and command status
// depends on olt_pkg and the ordered_list_table rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = olt_pkg::DEPTH_DEF;
  localparam int CMD_W = olt_pkg::CMD_W;
  localparam int POS_W = olt_pkg::POS_W;
  localparam int VAL_W = olt_pkg::VAL_W;
  localparam int STS_W = olt_pkg::STS_W;
  localparam int FND_W = olt_pkg::FND_W;
  localparam int CNT_W = olt_pkg::CNT_W;
  localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;  // unused code, no change and status ok
  localparam int N_RANDOM     = 1600;
  localparam int PHASE1_AT    = 560;
  localparam int PHASE2_AT    = 1100;
  localparam int HOLD_AT      = 1250;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = DEPTH + 16;

  typedef struct {
    logic [CMD_W-1:0] op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
  } list_cmd_t;

  typedef struct {
    logic [STS_W-1:0] status;
    logic [FND_W-1:0] found;
    logic [CNT_W-1:0] count;
  } list_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // position [5:0], value [37:6], zero pad [39:38]
  logic [2:0]  in_tuser;   // command [2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // found_index [5:0], count [12:6], zero pad [15:13]
  logic [2:0]  out_tuser;  // status [2:0]

  list_cmd_t cmd_backlog[$];
  list_res_t due_results[$];

  logic [VAL_W-1:0] shadow_mem [DEPTH];
  int shadow_len = 0;
  int plan_len   = 0;
  int n_taken    = 0;
  int mismatches = 0;
  bit in_took    = 0;
  bit rcv_hold   = 0;

  ordered_list_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // applies one command to the shadow list and returns the result it must produce
  function automatic list_res_t apply_cmd(list_cmd_t c);
    list_res_t r;
    int at;
    r.status = olt_pkg::ST_OK;
    r.found  = '0;
    case (c.op)
      olt_pkg::CMD_PUSH_BACK, olt_pkg::CMD_PUSH_FRONT, olt_pkg::CMD_INSERT: begin
        at = (c.op == olt_pkg::CMD_PUSH_BACK) ? shadow_len :
             (c.op == olt_pkg::CMD_PUSH_FRONT) ? 0 : int'(c.pos);
        // full takes precedence over a bad position
        if (shadow_len >= DEPTH) r.status = olt_pkg::ST_FULL;
        else if (at > shadow_len) r.status = olt_pkg::ST_BADPOS;
        else begin
          for (int k = shadow_len; k > at; k--) shadow_mem[k] = shadow_mem[k-1];
          shadow_mem[at] = c.val;
          shadow_len++;
        end
      end
      olt_pkg::CMD_POP_BACK, olt_pkg::CMD_POP_FRONT, olt_pkg::CMD_ERASE: begin
        at = (c.op == olt_pkg::CMD_POP_BACK) ? shadow_len - 1 :
             (c.op == olt_pkg::CMD_POP_FRONT) ? 0 : int'(c.pos);
        if (shadow_len == 0) r.status = olt_pkg::ST_EMPTY;
        else if (at >= shadow_len) r.status = olt_pkg::ST_BADPOS;
        else begin
          for (int k = at; k + 1 < shadow_len; k++) shadow_mem[k] = shadow_mem[k+1];
          shadow_len--;
        end
      end
      olt_pkg::CMD_FIND: begin
        r.status = olt_pkg::ST_NOTFOUND;
        for (int k = 0; k < shadow_len; k++)
          if (r.status == olt_pkg::ST_NOTFOUND && shadow_mem[k] == c.val) begin
            r.status = olt_pkg::ST_OK;
            r.found  = FND_W'(k);
          end
      end
      default: ;
    endcase
    r.count = CNT_W'(shadow_len);
    return r;
  endfunction

  // queues one item and tracks the list length it will leave behind
  function automatic void plan_cmd(logic [CMD_W-1:0] op, int pos, logic [VAL_W-1:0] val);
    list_cmd_t c;
    c.op  = op;
    c.pos = POS_W'(pos);
    c.val = val;
    cmd_backlog.push_back(c);
    case (op)
      olt_pkg::CMD_PUSH_BACK, olt_pkg::CMD_PUSH_FRONT, olt_pkg::CMD_INSERT:
        if (plan_len < DEPTH && (op != olt_pkg::CMD_INSERT || pos <= plan_len)) plan_len++;
      olt_pkg::CMD_POP_BACK, olt_pkg::CMD_POP_FRONT, olt_pkg::CMD_ERASE:
        if (plan_len > 0 && (op != olt_pkg::CMD_ERASE || pos < plan_len)) plan_len--;
      default: ;
    endcase
  endfunction

  // driver: offers the next item and sets the receiver's ready at the falling edge
  always @(negedge clk) begin
    list_cmd_t nxt;
    int s_idle;
    int r_idle;
    s_idle = (n_taken < PHASE1_AT) ? 37 : (n_taken < PHASE2_AT) ? 83 : 0;
    r_idle = (n_taken < PHASE1_AT) ? 83 : (n_taken < PHASE2_AT) ? 37 : 0;
    if (rst_n && (!in_tvalid || in_took)) begin
      if (cmd_backlog.size() > 0 && $urandom_range(99) >= s_idle) begin
        nxt = cmd_backlog.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {2'b00, nxt.val, nxt.pos};
        in_tuser  <= nxt.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= rst_n && !rcv_hold && ($urandom_range(99) >= r_idle);
  end

  // monitor: checks each result against the oldest prediction, predicts accepted items
  always @(posedge clk) begin
    list_res_t want;
    list_cmd_t got_cmd;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: status %0d, found_index %0d, count %0d",
                 out_tuser, out_tdata[5:0], out_tdata[12:6]);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_tuser);
            mismatches++;
          end
          if (out_tdata[5:0] !== want.found) begin
            $error("found_index: expected %0d, actual %0d", want.found, out_tdata[5:0]);
            mismatches++;
          end
          if (out_tdata[12:6] !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, out_tdata[12:6]);
            mismatches++;
          end
        end
      end
      in_took = in_tvalid && in_tready;
      if (in_took) begin
        got_cmd.op  = in_tuser;
        got_cmd.pos = in_tdata[5:0];
        got_cmd.val = in_tdata[37:6];
        due_results.push_back(apply_cmd(got_cmd));
        n_taken++;
      end
    end
  end

  // long receiver hold-off while the sender keeps offering, so the input stalls
  initial begin
    wait (n_taken >= HOLD_AT);
    rcv_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rcv_hold = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("FAIL ordered_list_table");
    $finish;
  end

  initial begin
    int mode;
    int burst;
    int roll;
    int pos;
    int planned;
    logic [CMD_W-1:0] op;
    logic [VAL_W-1:0] val;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;

    // directed: empty list cases, extremes, append by insert, bad positions, finds
    plan_cmd(olt_pkg::CMD_FIND,       0, 32'h0000_0000);
    plan_cmd(olt_pkg::CMD_POP_BACK,   0, 32'h0000_0000);
    plan_cmd(olt_pkg::CMD_POP_FRONT,  0, 32'h0000_0000);
    plan_cmd(olt_pkg::CMD_ERASE,      0, 32'h0000_0000);
    plan_cmd(olt_pkg::CMD_INSERT,     1, 32'h1234_5678);
    plan_cmd(olt_pkg::CMD_INSERT,     0, 32'h7FFF_FFFF);
    plan_cmd(olt_pkg::CMD_PUSH_FRONT, 0, 32'h8000_0000);
    plan_cmd(olt_pkg::CMD_PUSH_BACK,  0, 32'h0000_0000);
    plan_cmd(olt_pkg::CMD_INSERT,     3, 32'hFFFF_FFFF);
    plan_cmd(olt_pkg::CMD_INSERT,    63, 32'h0000_0001);
    plan_cmd(olt_pkg::CMD_INSERT,     1, 32'h5555_5555);
    plan_cmd(olt_pkg::CMD_FIND,      63, 32'hFFFF_FFFF);
    plan_cmd(olt_pkg::CMD_FIND,       0, 32'h8000_0000);
    plan_cmd(olt_pkg::CMD_FIND,       0, 32'h0000_3039);
    plan_cmd(olt_pkg::CMD_ERASE,      5, 32'h0000_0000);
    plan_cmd(olt_pkg::CMD_ERASE,     63, 32'h0000_0000);
    plan_cmd(olt_pkg::CMD_ERASE,      4, 32'h0000_0000);
    plan_cmd(olt_pkg::CMD_ERASE,      1, 32'h0000_0000);
    plan_cmd(CMD_SPARE,              63, 32'hAAAA_AAAA);
    plan_cmd(olt_pkg::CMD_POP_FRONT, 42, 32'hFFFF_FFFF);
    plan_cmd(olt_pkg::CMD_POP_BACK,  21, 32'h0000_0000);
    plan_cmd(olt_pkg::CMD_PUSH_BACK,  0, 32'hAAAA_AAAA);
    plan_cmd(olt_pkg::CMD_FIND,       0, 32'hAAAA_AAAA);

    // random: grow, shrink and mixed bursts, values half the time from a small pool
    planned = 0;
    while (planned < N_RANDOM) begin
      mode  = $urandom_range(2);
      burst = $urandom_range(120, 30);
      for (int i = 0; i < burst && planned < N_RANDOM; i++) begin
        roll = $urandom_range(99);
        if (roll < 2) op = CMD_SPARE;
        else if (roll < 6 || mode == 2) op = CMD_W'($urandom_range(6));
        else if (mode == 0)
          op = (roll < 30) ? olt_pkg::CMD_PUSH_BACK : (roll < 50) ? olt_pkg::CMD_PUSH_FRONT :
               (roll < 75) ? olt_pkg::CMD_INSERT : (roll < 88) ? olt_pkg::CMD_FIND :
               (roll < 94) ? olt_pkg::CMD_POP_FRONT : olt_pkg::CMD_ERASE;
        else
          op = (roll < 30) ? olt_pkg::CMD_POP_BACK : (roll < 50) ? olt_pkg::CMD_POP_FRONT :
               (roll < 75) ? olt_pkg::CMD_ERASE : (roll < 88) ? olt_pkg::CMD_FIND :
               (roll < 94) ? olt_pkg::CMD_PUSH_BACK : olt_pkg::CMD_INSERT;

        pos = $urandom_range(63);
        if (op == olt_pkg::CMD_INSERT && $urandom_range(9) > 1)
          pos = $urandom_range(plan_len > 63 ? 63 : plan_len);
        if (op == olt_pkg::CMD_ERASE && plan_len > 0 && $urandom_range(9) > 1)
          pos = $urandom_range(plan_len - 1);

        roll = $urandom_range(9);
        if (roll < 5) val = $urandom_range(15) - 8;
        else if (roll == 5) val = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        else val = $urandom();

        plan_cmd(op, pos, val);
        planned++;
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() != 0 || in_tvalid || due_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS ordered_list_table");
    end else begin
      $display("FAIL ordered_list_table");
    end
    $finish;
  end

endmodule
